FILE: sv/trk_pkg.sv
// trk_pkg: constants and types for the top-k frequency ranker
// used by trk_cell and stream_top_k_frequency_ranker, no dependencies
package trk_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int MAX_TOP    = 10;

  localparam int ID_W   = 16;
  localparam int CNT_W  = 16;
  localparam int SLOT_W = 4;
  localparam int TOP_W  = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [TOP_W-1:0] TOP_RESET = 4'd3;

  localparam int USED_W = $clog2(LIST_DEPTH + 1);
  localparam int WANT_W = $clog2(MAX_TOP + 1);
  localparam int CMP_W  = (USED_W > WANT_W) ? USED_W : WANT_W;
  localparam int TAP    = (MAX_TOP < LIST_DEPTH) ? MAX_TOP : LIST_DEPTH;

  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (LIST_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             upd;
    logic             found;
    logic [ID_W-1:0]  qid;
    logic [CNT_W-1:0] c_old;
    logic [CNT_W-1:0] c_new;
  } trk_bcast_t;

  // neighbour link from cell i-1 to cell i
  typedef struct packed {
    logic             valid;
    logic             shift;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
  } trk_link_t;

endpackage

FILE: sv/stream_top_k_frequency_ranker.sv
// stream_top_k_frequency_ranker: ranked frequency list as a chain of trk_cell slots
// depends on trk_pkg and trk_cell
//
//   channel  handshake              payload
//   input    in_valid / in_ready    item_id
//   output   out_valid / out_ready  query_id rank_slot recommended_id present last dropped
//   config   cfg_we                 cfg_wdata (top_count)
//
// each item runs through the registered match tree over the cells, then a run of n
// outputs, n = min(top_count held to 1..10, entries in list) or 1 when empty, then
// the parallel shift of the chain; the next transfer is taken on the following cycle
// reset clears all counts at once, no clearing pass; top_count resets to 3
// a stalled output holds its register and delays the run, the update waits for it
module stream_top_k_frequency_ranker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [trk_pkg::ID_W-1:0]    item_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [trk_pkg::ID_W-1:0]    query_id,
  output logic [trk_pkg::SLOT_W-1:0]  rank_slot,
  output logic [trk_pkg::ID_W-1:0]    recommended_id,
  output logic                        present,
  output logic                        last,
  output logic                        dropped,
  input  logic                        cfg_we,
  input  logic [trk_pkg::TOP_W-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRP  = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]                      state;
  logic [trk_pkg::TOP_W-1:0]       top_count;
  logic [trk_pkg::ID_W-1:0]        qid;
  logic [trk_pkg::WANT_W-1:0]      want;
  logic [trk_pkg::WANT_W-1:0]      k;
  logic [trk_pkg::USED_W-1:0]      used;
  logic                            found;
  logic [trk_pkg::CNT_W-1:0]       c_old;
  logic [trk_pkg::CNT_W:0]         grp [trk_pkg::NUM_GROUPS];
  logic [trk_pkg::CNT_W:0]         grp_next [trk_pkg::NUM_GROUPS];
  logic [trk_pkg::CNT_W:0]         red_next;

  trk_pkg::trk_bcast_t             bc;
  trk_pkg::trk_link_t              links [trk_pkg::LIST_DEPTH+1];
  logic                            hits [trk_pkg::LIST_DEPTH];

  logic                            full, drop, emit_go, emit_last, in_xfer;
  logic [trk_pkg::CMP_W-1:0]       n_run;
  logic [trk_pkg::WANT_W-1:0]      n_eff;
  logic [trk_pkg::WANT_W-1:0]      want_next;
  logic [trk_pkg::ID_W-1:0]        rec_id;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (used == trk_pkg::USED_W'(trk_pkg::LIST_DEPTH));
  assign drop     = !found && full;

  // chain of cells
  assign links[0] = '{valid: 1'b1, shift: 1'b0, id: '0, cnt: '0};

  always_comb begin
    bc.upd   = (state == S_UPD) && (found || !full);
    bc.found = found;
    bc.qid   = qid;
    bc.c_old = found ? c_old : '0;
    if (!found) begin
      bc.c_new = trk_pkg::CNT_W'(1);
    end else if (c_old == trk_pkg::COUNT_MAX) begin
      bc.c_new = c_old;
    end else begin
      bc.c_new = c_old + trk_pkg::CNT_W'(1);
    end
  end

  for (genvar i = 0; i < trk_pkg::LIST_DEPTH; i++) begin : g_cell
    trk_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .bc   (bc),
      .prev (links[i]),
      .link (links[i+1]),
      .hit  (hits[i])
    );
  end

  // match tree, one registered level per group then one over the groups
  always_comb begin
    int idx;
    for (int g = 0; g < trk_pkg::NUM_GROUPS; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < trk_pkg::GROUP_SIZE; j++) begin
        idx = g * trk_pkg::GROUP_SIZE + j;
        if (idx < trk_pkg::LIST_DEPTH) begin
          if (hits[idx]) begin
            grp_next[g] = grp_next[g] | {1'b1, links[idx+1].cnt};
          end
        end
      end
    end
    red_next = '0;
    for (int g = 0; g < trk_pkg::NUM_GROUPS; g++) begin
      red_next = red_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GRP) begin
      for (int g = 0; g < trk_pkg::NUM_GROUPS; g++) begin
        grp[g] <= grp_next[g];
      end
    end
    if (state == S_RED) begin
      found <= red_next[trk_pkg::CNT_W];
      c_old <= red_next[trk_pkg::CNT_W-1:0];
    end
  end

  // run length and tap select
  always_comb begin
    if (top_count == '0) begin
      want_next = trk_pkg::WANT_W'(1);
    end else if (32'(top_count) > trk_pkg::MAX_TOP) begin
      want_next = trk_pkg::WANT_W'(trk_pkg::MAX_TOP);
    end else begin
      want_next = trk_pkg::WANT_W'(top_count);
    end
    if (trk_pkg::CMP_W'(used) < trk_pkg::CMP_W'(want)) begin
      n_run = trk_pkg::CMP_W'(used);
    end else begin
      n_run = trk_pkg::CMP_W'(want);
    end
    n_eff     = (n_run == '0) ? trk_pkg::WANT_W'(1) : trk_pkg::WANT_W'(n_run);
    emit_last = ((k + trk_pkg::WANT_W'(1)) == n_eff);
    emit_go   = (state == S_EMIT) && (!out_valid || out_ready);
    rec_id    = '0;
    for (int t = 0; t < trk_pkg::TAP; t++) begin
      if (k == trk_pkg::WANT_W'(t)) begin
        rec_id = links[t+1].id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= trk_pkg::TOP_RESET;
    end else if (cfg_we) begin
      top_count <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_GRP;
            k     <= '0;
          end
        end
        S_GRP: begin
          state <= S_RED;
        end
        S_RED: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            k <= k + trk_pkg::WANT_W'(1);
            if (emit_last) begin
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (!found && !full) begin
            used <= used + trk_pkg::USED_W'(1);
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      qid  <= item_id;
      want <= want_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      query_id       <= qid;
      rank_slot      <= trk_pkg::SLOT_W'(k);
      recommended_id <= (n_run == '0) ? '0 : rec_id;
      present        <= (n_run != '0);
      last           <= emit_last;
      dropped        <= emit_last && drop;
    end
  end

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= trk_pkg::USED_W'(trk_pkg::LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_append: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && !found && !full) |=> (used == $past(used) + trk_pkg::USED_W'(1)))
    else $error("new id not appended");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped) |-> (last && full))
    else $error("drop flagged while list not full");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (links[1].cnt >= links[2].cnt))
    else $error("head of list out of order");

endmodule

FILE: sv/trk_cell.sv
// trk_cell: one slot of the ranked list, holds an id and its count
// depends on trk_pkg; chained by stream_top_k_frequency_ranker
module trk_cell (
  input  logic               clk,
  input  logic               rst,
  input  trk_pkg::trk_bcast_t bc,
  input  trk_pkg::trk_link_t  prev,
  output trk_pkg::trk_link_t  link,
  output logic               hit
);

  logic [trk_pkg::ID_W-1:0]  id;
  logic [trk_pkg::CNT_W-1:0] cnt;
  logic valid, gt_old, lt_new, shift, is_pos, take_prev, take_new;

  always_comb begin
    valid     = (cnt != '0);
    hit       = valid && (id == bc.qid);
    gt_old    = (cnt > bc.c_old) || ((cnt == bc.c_old) && (id < bc.qid));
    lt_new    = (cnt < bc.c_new) || ((cnt == bc.c_new) && (id > bc.qid));
    shift     = valid && gt_old && lt_new;
    is_pos    = bc.found ? hit : (!valid && prev.valid);
    take_prev = prev.shift && (shift || is_pos);
    take_new  = !prev.shift && (shift || is_pos);
    link.valid = valid;
    link.shift = shift;
    link.id    = id;
    link.cnt   = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (bc.upd) begin
      if (take_prev) begin
        cnt <= prev.cnt;
      end else if (take_new) begin
        cnt <= bc.c_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bc.upd) begin
      if (take_prev) begin
        id <= prev.id;
      end else if (take_new) begin
        id <= bc.qid;
      end
    end
  end

endmodule
